[sv/gvmc_pkg.sv]
// Shared types and codes for the graph vertex merge/contract/split engine.
// Used by the channel interfaces and the top level; depends on nothing.
`default_nettype none

package gvmc_pkg;

    // Default matrix size (vertices, also columns per row)
    localparam int MAX_VERTICES = 64;

    // Fixed field widths of the channels
    localparam int MODE_W   = 3;
    localparam int VIDX_W   = 6;
    localparam int ROW_W    = 64;
    localparam int COUNT_W  = 7;
    localparam int STATUS_W = 2;

    typedef logic [MODE_W-1:0]   mode_t;
    typedef logic [VIDX_W-1:0]   vidx_t;
    typedef logic [ROW_W-1:0]    row_t;
    typedef logic [COUNT_W-1:0]  count_t;
    typedef logic [STATUS_W-1:0] status_t;

    // Item modes
    localparam mode_t MODE_WRITE    = 3'd0;
    localparam mode_t MODE_COUNT    = 3'd1;
    localparam mode_t MODE_IDENTIFY = 3'd2;
    localparam mode_t MODE_CONTRACT = 3'd3;
    localparam mode_t MODE_SPLIT    = 3'd4;
    localparam mode_t MODE_READ     = 3'd5;

    // Result status codes
    localparam status_t ST_OK     = 2'd0;
    localparam status_t ST_BAD    = 2'd1;
    localparam status_t ST_NOEDGE = 2'd2;
    localparam status_t ST_FULL   = 2'd3;

endpackage

`default_nettype wire

[sv/gvmc_req_if.sv]
// Request channel: one word carries a mode and its operands.
// Depends on gvmc_pkg for field types.
`default_nettype none

interface gvmc_req_if;
    logic              valid;
    logic              ready;
    gvmc_pkg::mode_t   mode;
    gvmc_pkg::vidx_t   vertex_a;
    gvmc_pkg::vidx_t   vertex_b;
    gvmc_pkg::row_t    row_bits;
    gvmc_pkg::count_t  new_count;

    modport source (output valid, output mode, output vertex_a, output vertex_b,
                    output row_bits, output new_count, input ready);
    modport sink   (input valid, input mode, input vertex_a, input vertex_b,
                    input row_bits, input new_count, output ready);
endinterface

`default_nettype wire

[sv/gvmc_rsp_if.sv]
// Response channel: one word of status, vertex count and row data.
// Depends on gvmc_pkg for field types.
`default_nettype none

interface gvmc_rsp_if;
    logic              valid;
    logic              ready;
    gvmc_pkg::status_t status;
    gvmc_pkg::count_t  vertex_count;
    gvmc_pkg::row_t    row_data;

    modport source (output valid, output status, output vertex_count,
                    output row_data, input ready);
    modport sink   (input valid, input status, input vertex_count,
                    input row_data, output ready);
endinterface

`default_nettype wire

[sv/graph_vertex_merge_contract_split_top.sv]
// Top level of the adjacency matrix vertex merge/contract/split engine.
// Depends on gvmc_pkg, gvmc_req_if and gvmc_rsp_if.
//
//   Channel  Dir  Payload                                     Handshake
//   req      in   mode, vertex_a, vertex_b, row_bits,          valid/ready
//                 new_count
//   rsp      out  status, vertex_count, row_data              valid/ready
//
// One request word at a time; req.ready is high only while the sequencer idles.
// Write, set count and range errors go to done; read and a no-edge contract pass
// the read or check state. Identify and contract sweep, merge, shift; split
// sweeps, appends. The matrix memory has one read and one write port, so every
// row sweep moves one row per cycle. Reset clears the count and row valid bits.
// A pending response waits in its own register while the next request is taken.
`default_nettype none

module graph_vertex_merge_contract_split_top #(
    parameter int MAX_VERTICES = gvmc_pkg::MAX_VERTICES
) (
    input  logic          clk,
    input  logic          rst_n,
    gvmc_req_if.sink      req,
    gvmc_rsp_if.source    rsp
);

    localparam int RW = MAX_VERTICES;
    localparam int AW = $clog2(MAX_VERTICES);
    localparam gvmc_pkg::count_t MAX_CNT = gvmc_pkg::COUNT_W'(MAX_VERTICES);

    typedef logic [RW-1:0] mrow_t;
    typedef logic [AW-1:0] addr_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_READ,
        S_SWEEP,
        S_MERGE,
        S_SHIFT,
        S_APPEND,
        S_DONE
    } state_t;

    // Mask of the columns below k
    function automatic mrow_t mask_low(input gvmc_pkg::count_t k);
        mrow_t m;
        for (int j = 0; j < RW; j++)
        begin
            m[j] = (gvmc_pkg::COUNT_W'(j) < k);
        end
        return m;
    endfunction

    // Single set bit at column i
    function automatic mrow_t one_hot(input addr_t i);
        mrow_t m;
        m    = '0;
        m[i] = 1'b1;
        return m;
    endfunction

    // Control and operand registers
    state_t              state_reg, state_next;
    gvmc_pkg::mode_t     op_reg, op_next;
    gvmc_pkg::vidx_t     a_reg, a_next;
    gvmc_pkg::vidx_t     b_reg, b_next;
    gvmc_pkg::count_t    idx_reg, idx_next;
    logic                pend_reg, pend_next;
    addr_t               dst_reg, dst_next;
    mrow_t               hold_a_reg, hold_a_next;
    mrow_t               hold_b_reg, hold_b_next;
    gvmc_pkg::count_t    count_reg, count_next;
    gvmc_pkg::status_t   status_reg, status_next;
    mrow_t               data_reg, data_next;
    logic                rsp_valid_reg, rsp_valid_next;
    gvmc_pkg::status_t   rsp_status_reg, rsp_status_next;
    gvmc_pkg::count_t    rsp_count_reg, rsp_count_next;
    gvmc_pkg::row_t      rsp_data_reg, rsp_data_next;

    // Matrix memory and its row valid bits
    mrow_t               mem [MAX_VERTICES];
    logic [RW-1:0]       valid_reg;
    mrow_t               rd_q_reg;
    logic                rd_vld_reg;

    logic                mem_re;
    addr_t               mem_raddr;
    logic                mem_we;
    addr_t               mem_waddr;
    mrow_t               mem_wdata;
    logic                clr_en;
    gvmc_pkg::count_t    clr_from;

    logic                accept;
    mrow_t               rd_row;
    addr_t               a_idx, b_idx, n_idx;
    mrow_t               bit_a, bit_n, below_b;
    mrow_t               sweep_w, shift_w;
    gvmc_pkg::count_t    src_idx;
    logic                is_split;

    assign req.ready        = (state_reg == S_IDLE);
    assign accept           = req.valid && req.ready;
    assign rsp.valid        = rsp_valid_reg;
    assign rsp.status       = rsp_status_reg;
    assign rsp.vertex_count = rsp_count_reg;
    assign rsp.row_data     = rsp_data_reg;

    // Row read back; a row never written since its last clear reads as zero
    assign rd_row   = rd_vld_reg ? rd_q_reg : '0;
    assign a_idx    = a_reg[AW-1:0];
    assign b_idx    = b_reg[AW-1:0];
    assign n_idx    = count_reg[AW-1:0];
    assign bit_a    = one_hot(a_idx);
    assign bit_n    = one_hot(n_idx);
    assign below_b  = mask_low({1'b0, b_reg});
    assign is_split = (op_reg == gvmc_pkg::MODE_SPLIT);

    // Shared row unit: column fold for merge, column copy for split
    always_comb
    begin
        if (is_split)
        begin
            sweep_w = ((rd_row & ~bit_n) | (rd_row[a_idx] ? bit_n : '0))
                      & mask_low(count_reg + gvmc_pkg::COUNT_W'(1));
        end
        else
        begin
            sweep_w = rd_row | (rd_row[b_idx] ? bit_a : '0);
        end
    end

    // Column removal: drop column b, move higher columns down one bit
    assign shift_w = ((rd_row & below_b) | ((rd_row >> 1) & ~below_b))
                     & mask_low(count_reg - gvmc_pkg::COUNT_W'(1));
    assign src_idx = (idx_reg < {1'b0, b_reg}) ? idx_reg
                                               : idx_reg + gvmc_pkg::COUNT_W'(1);

    // Sequencer next-state logic
    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        idx_next        = idx_reg;
        pend_next       = 1'b0;
        dst_next        = dst_reg;
        hold_a_next     = hold_a_reg;
        hold_b_next     = hold_b_reg;
        count_next      = count_reg;
        status_next     = status_reg;
        data_next       = data_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        rsp_status_next = rsp_status_reg;
        rsp_count_next  = rsp_count_reg;
        rsp_data_next   = rsp_data_reg;
        mem_re          = 1'b0;
        mem_raddr       = a_idx;
        mem_we          = 1'b0;
        mem_waddr       = a_idx;
        mem_wdata       = '0;
        clr_en          = 1'b0;
        clr_from        = count_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next     = req.mode;
                    a_next      = req.vertex_a;
                    b_next      = req.vertex_b;
                    idx_next    = '0;
                    status_next = gvmc_pkg::ST_OK;
                    data_next   = '0;
                    state_next  = S_DONE;
                    case (req.mode)
                        gvmc_pkg::MODE_WRITE:
                        begin
                            if ({1'b0, req.vertex_a} >= MAX_CNT)
                            begin
                                status_next = gvmc_pkg::ST_BAD;
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = req.vertex_a[AW-1:0];
                                mem_wdata = req.row_bits[RW-1:0];
                            end
                        end
                        gvmc_pkg::MODE_COUNT:
                        begin
                            if (req.new_count > MAX_CNT)
                            begin
                                status_next = gvmc_pkg::ST_BAD;
                            end
                            else
                            begin
                                count_next = req.new_count;
                            end
                        end
                        gvmc_pkg::MODE_IDENTIFY,
                        gvmc_pkg::MODE_CONTRACT:
                        begin
                            if ({1'b0, req.vertex_a} >= count_reg ||
                                {1'b0, req.vertex_b} >= count_reg ||
                                req.vertex_a == req.vertex_b)
                            begin
                                status_next = gvmc_pkg::ST_BAD;
                            end
                            else if (req.mode == gvmc_pkg::MODE_CONTRACT)
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = req.vertex_a[AW-1:0];
                                state_next = S_CHECK;
                            end
                            else
                            begin
                                state_next = S_SWEEP;
                            end
                        end
                        gvmc_pkg::MODE_SPLIT:
                        begin
                            if ({1'b0, req.vertex_a} >= count_reg)
                            begin
                                status_next = gvmc_pkg::ST_BAD;
                            end
                            else if (count_reg >= MAX_CNT)
                            begin
                                status_next = gvmc_pkg::ST_FULL;
                            end
                            else
                            begin
                                state_next = S_SWEEP;
                            end
                        end
                        gvmc_pkg::MODE_READ:
                        begin
                            if ({1'b0, req.vertex_a} >= count_reg)
                            begin
                                status_next = gvmc_pkg::ST_BAD;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = req.vertex_a[AW-1:0];
                                state_next = S_READ;
                            end
                        end
                        default:
                        begin
                            status_next = gvmc_pkg::ST_BAD;
                        end
                    endcase
                end
            end

            // Contract needs the edge a-b before anything changes
            S_CHECK:
            begin
                if (rd_row[b_idx])
                begin
                    state_next = S_SWEEP;
                end
                else
                begin
                    status_next = gvmc_pkg::ST_NOEDGE;
                    state_next  = S_DONE;
                end
            end

            S_READ:
            begin
                data_next  = rd_row & mask_low(count_reg);
                state_next = S_DONE;
            end

            // Sweep rows 0..n-1: read one row, write back the previous one
            S_SWEEP:
            begin
                if (idx_reg < count_reg)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = idx_reg[AW-1:0];
                    pend_next = 1'b1;
                    dst_next  = idx_reg[AW-1:0];
                    idx_next  = idx_reg + gvmc_pkg::COUNT_W'(1);
                end
                if (pend_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = dst_reg;
                    mem_wdata = sweep_w;
                    if (dst_reg == a_idx)
                    begin
                        hold_a_next = sweep_w;
                    end
                    if (dst_reg == b_idx)
                    begin
                        hold_b_next = sweep_w;
                    end
                end
                if (idx_reg >= count_reg && !pend_reg)
                begin
                    idx_next   = '0;
                    state_next = is_split ? S_APPEND : S_MERGE;
                end
            end

            // Fold row b into row a; contract drops the loop at a
            S_MERGE:
            begin
                mem_we    = 1'b1;
                mem_waddr = a_idx;
                mem_wdata = (hold_a_reg | hold_b_reg)
                            & ((op_reg == gvmc_pkg::MODE_CONTRACT) ? ~bit_a : '1);
                state_next = S_SHIFT;
            end

            // Move rows above b down one place, drop column b, trim to n-1
            S_SHIFT:
            begin
                if (idx_reg < count_reg - gvmc_pkg::COUNT_W'(1))
                begin
                    mem_re    = 1'b1;
                    mem_raddr = src_idx[AW-1:0];
                    pend_next = 1'b1;
                    dst_next  = idx_reg[AW-1:0];
                    idx_next  = idx_reg + gvmc_pkg::COUNT_W'(1);
                end
                if (pend_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = dst_reg;
                    mem_wdata = shift_w;
                end
                if (idx_reg >= count_reg - gvmc_pkg::COUNT_W'(1) && !pend_reg)
                begin
                    clr_en     = 1'b1;
                    clr_from   = count_reg - gvmc_pkg::COUNT_W'(1);
                    count_next = count_reg - gvmc_pkg::COUNT_W'(1);
                    state_next = S_DONE;
                end
            end

            // Append the copy of vertex a as the new last row
            S_APPEND:
            begin
                mem_we     = 1'b1;
                mem_waddr  = n_idx;
                mem_wdata  = hold_a_reg & mask_low(count_reg);
                clr_en     = 1'b1;
                clr_from   = count_reg + gvmc_pkg::COUNT_W'(1);
                count_next = count_reg + gvmc_pkg::COUNT_W'(1);
                state_next = S_DONE;
            end

            // Hand the result to the response register once it is free
            S_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = status_reg;
                    rsp_count_next  = count_reg;
                    rsp_data_next   = gvmc_pkg::ROW_W'(data_reg);
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pend_reg      <= 1'b0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        a_reg          <= a_next;
        b_reg          <= b_next;
        idx_reg        <= idx_next;
        dst_reg        <= dst_next;
        hold_a_reg     <= hold_a_next;
        hold_b_reg     <= hold_b_next;
        status_reg     <= status_next;
        data_reg       <= data_next;
        rsp_status_reg <= rsp_status_next;
        rsp_count_reg  <= rsp_count_next;
        rsp_data_reg   <= rsp_data_next;
    end

    // Matrix memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_q_reg <= mem[mem_raddr];
        end
    end

    // Row valid bits: set on write, cleared from a row index upward
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            for (int j = 0; j < RW; j++)
            begin
                if (mem_we && mem_waddr == AW'(j))
                begin
                    valid_reg[j] <= 1'b1;
                end
                else if (clr_en && gvmc_pkg::COUNT_W'(j) >= clr_from)
                begin
                    valid_reg[j] <= 1'b0;
                end
            end
            if (mem_re)
            begin
                rd_vld_reg <= valid_reg[mem_raddr];
            end
        end
    end

endmodule

`default_nettype wire

[test/tb.sv]
`timescale 1ns / 100ps
// Testbench for graph_vertex_merge_contract_split_top: a directed table, then random words,
// each reply checked against an adjacency matrix model in this bench or a typed reply.
// Depends on gvmc_pkg, gvmc_req_if, gvmc_rsp_if and the top level.

module tb;
    import gvmc_pkg::*;

    localparam int MAX_V     = gvmc_pkg::MAX_VERTICES;
    localparam int DIR_N     = 25;
    localparam int RAND_N    = 1152;
    localparam int PHASE_N   = 4;
    localparam int DRAIN_CYC = 200;
    localparam int HOLD_CYC  = 400;
    localparam int LIMIT_CYC = 1000000;

    // Modes the block has to reject
    localparam mode_t MODE_SPARE6 = 3'd6;
    localparam mode_t MODE_SPARE7 = 3'd7;

    // One request word; typed rows carry their reply written out by hand
    typedef struct packed {
        mode_t   mode;
        vidx_t   va;
        vidx_t   vb;
        row_t    bits;
        count_t  cnt;
        logic    typed;
        status_t st;
        count_t  n;
        row_t    data;
    } op_word_t;

    typedef struct packed {
        status_t st;
        count_t  n;
        row_t    data;
    } reply_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    gvmc_req_if req_ch ();
    gvmc_rsp_if rsp_ch ();

    graph_vertex_merge_contract_split_top #(.MAX_VERTICES(MAX_V)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Matrix and count as the block should hold them
    row_t     adj_rows [MAX_V];
    count_t   adj_count;
    reply_t   graph_replies [$];

    int       errors = 0;
    int       words_sent = 0;
    int       words_back = 0;
    int       mode_hits [8];
    int       status_hits [4];
    int       send_idle_pct = 0;
    int       recv_stall_pct = 0;
    int       hold_epoch = 0;
    op_word_t directed [DIR_N];

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    function automatic row_t cols_below(int n);
        if (n >= ROW_W)
            return '1;
        return (row_t'(1) << n) - row_t'(1);
    endfunction

    // Keep rows below n masked to n columns, clear the rest
    function automatic void trim_to(int n);
        row_t m;
        m = cols_below(n);
        for (int i = 0; i < MAX_V; i++)
            adj_rows[i] = (i < n) ? (adj_rows[i] & m) : '0;
    endfunction

    // Fold vertex b into a, then remove row and column b
    function automatic void merge_drop(int a, int b, int n, logic clear_loop);
        row_t below;
        row_t r;
        row_t hi;
        below = cols_below(b);
        for (int i = 0; i < n; i++)
            if (adj_rows[i][b])
                adj_rows[i][a] = 1'b1;
        adj_rows[a] |= adj_rows[b];
        if (clear_loop)
            adj_rows[a][a] = 1'b0;
        for (int i = 0; i + 1 < n; i++)
        begin
            r  = adj_rows[(i < b) ? i : i + 1];
            hi = (b >= ROW_W - 1) ? '0 : ((r >> (b + 1)) << b);
            adj_rows[i] = (r & below) | hi;
        end
        trim_to(n - 1);
    endfunction

    // Apply one word to the matrix and return the reply it earns
    function automatic reply_t apply_vertex_op(op_word_t w);
        reply_t rp;
        int     n;
        int     a;
        int     b;
        n = adj_count;
        a = w.va;
        b = w.vb;
        rp.st = ST_OK;
        rp.data = '0;
        case (w.mode)
            MODE_WRITE:
                if (a >= MAX_V)
                    rp.st = ST_BAD;
                else
                    adj_rows[a] = w.bits & cols_below(MAX_V);
            MODE_COUNT:
                if (w.cnt > MAX_V)
                    rp.st = ST_BAD;
                else
                    adj_count = w.cnt;
            MODE_IDENTIFY, MODE_CONTRACT:
                if (a >= n || b >= n || a == b)
                    rp.st = ST_BAD;
                else if (w.mode == MODE_CONTRACT && !adj_rows[a][b])
                    rp.st = ST_NOEDGE;
                else
                begin
                    merge_drop(a, b, n, w.mode == MODE_CONTRACT);
                    adj_count = count_t'(n - 1);
                end
            MODE_SPLIT:
                if (a >= n)
                    rp.st = ST_BAD;
                else if (n >= MAX_V)
                    rp.st = ST_FULL;
                else
                begin
                    for (int i = 0; i < n; i++)
                        adj_rows[i][n] = adj_rows[i][a];
                    adj_rows[n] = adj_rows[a] & cols_below(n);
                    adj_count = count_t'(n + 1);
                    trim_to(n + 1);
                end
            MODE_READ:
                if (a >= n)
                    rp.st = ST_BAD;
                else
                    rp.data = adj_rows[a] & cols_below(n);
            default:
                rp.st = ST_BAD;
        endcase
        rp.n = adj_count;
        return rp;
    endfunction

    function automatic op_word_t table_row(mode_t m, int a, int b, row_t bits, int cnt,
                                           logic typed, status_t st, int n, row_t data);
        op_word_t w;
        w = '0;
        w.mode  = m;
        w.va    = vidx_t'(a);
        w.vb    = vidx_t'(b);
        w.bits  = bits;
        w.cnt   = count_t'(cnt);
        w.typed = typed;
        w.st    = st;
        w.n     = count_t'(n);
        w.data  = data;
        return w;
    endfunction

    // Mostly well-formed operations on live vertices, some rejected words
    function automatic op_word_t pick_random_word();
        op_word_t w;
        int       n;
        int       r;
        int       a;
        int       j;
        int       bad;
        row_t     nbr;
        n = adj_count;
        w = '0;
        w.va   = vidx_t'($urandom);
        w.vb   = vidx_t'($urandom);
        w.bits = {$urandom, $urandom};
        w.cnt  = count_t'($urandom);
        r = $urandom_range(99);
        // Too few vertices for the chosen operation: set a new vertex count instead
        if ((r >= 36 && n == 0) || (r >= 52 && r < 84 && n < 2))
            r = 6;
        if (r < 6)
        begin
            case ($urandom_range(3))
                0:
                    w.mode = $urandom_range(1) ? MODE_SPARE6 : MODE_SPARE7;
                1:
                begin
                    w.mode = MODE_COUNT;
                    w.cnt  = count_t'($urandom_range(127, MAX_V + 1));
                end
                2:
                begin
                    case ($urandom_range(3))
                        0:       w.mode = MODE_IDENTIFY;
                        1:       w.mode = MODE_CONTRACT;
                        2:       w.mode = MODE_READ;
                        default: w.mode = MODE_SPLIT;
                    endcase
                    if (n < MAX_V)
                    begin
                        bad = $urandom_range(ROW_W - 1, n);
                        if (w.mode == MODE_READ || w.mode == MODE_SPLIT || $urandom_range(1))
                            w.va = vidx_t'(bad);
                        else
                            w.vb = vidx_t'(bad);
                    end
                    else
                    begin
                        w.mode = $urandom_range(1) ? MODE_IDENTIFY : MODE_CONTRACT;
                        w.vb   = w.va;
                    end
                end
                default:
                begin
                    w.mode = $urandom_range(1) ? MODE_IDENTIFY : MODE_CONTRACT;
                    w.vb   = w.va;
                end
            endcase
        end
        else if (r < 14)
        begin
            w.mode = MODE_COUNT;
            case ($urandom_range(2))
                0:       w.cnt = count_t'(MAX_V);
                1:       w.cnt = count_t'($urandom_range(MAX_V, 2));
                default: w.cnt = count_t'($urandom_range(MAX_V, 0));
            endcase
        end
        else if (r < 36)
        begin
            w.mode = MODE_WRITE;
            // Thin some rows out so missing edges turn up
            if ($urandom_range(3) == 0)
                w.bits &= {$urandom, $urandom};
        end
        else if (r < 52)
        begin
            w.mode = MODE_READ;
            w.va   = vidx_t'($urandom_range(n - 1, 0));
        end
        else if (r < 84)
        begin
            w.mode = (r < 66) ? MODE_IDENTIFY : MODE_CONTRACT;
            a = $urandom_range(n - 1, 0);
            nbr = adj_rows[a] & cols_below(n);
            nbr[a] = 1'b0;
            if (w.mode == MODE_CONTRACT && nbr != '0 && $urandom_range(3) != 0)
            begin
                // Take a real neighbor so the contraction goes through
                j = $urandom_range(ROW_W - 1, 0);
                while (!nbr[j])
                    j = (j + 1) % ROW_W;
            end
            else
            begin
                j = $urandom_range(n - 2, 0);
                if (j >= a)
                    j++;
            end
            w.va = vidx_t'(a);
            w.vb = vidx_t'(j);
        end
        else
        begin
            w.mode = MODE_SPLIT;
            w.va   = vidx_t'($urandom_range(n - 1, 0));
        end
        return w;
    endfunction

    // Offer one word, hold it until taken, then log the reply it earns
    task automatic offer_word(op_word_t w);
        reply_t rp;
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.mode      <= w.mode;
        req_ch.vertex_a  <= w.va;
        req_ch.vertex_b  <= w.vb;
        req_ch.row_bits  <= w.bits;
        req_ch.new_count <= w.cnt;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        rp = apply_vertex_op(w);
        if (w.typed)
        begin
            rp.st   = w.st;
            rp.n    = w.n;
            rp.data = w.data;
        end
        graph_replies.push_back(rp);
        mode_hits[w.mode]++;
        words_sent++;
        @(negedge clk);
    endtask

    // Drive reply ready: random stalls, plus a long hold-off on request
    initial
    begin : reply_accept
        int hold_left;
        int seen_epoch;
        hold_left = 0;
        seen_epoch = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_epoch != seen_epoch)
            begin
                seen_epoch = hold_epoch;
                hold_left = HOLD_CYC;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Check every reply word against the oldest logged one
    initial
    begin : reply_check
        reply_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
            begin
                words_back++;
                status_hits[rsp_ch.status]++;
                if (graph_replies.size() == 0)
                begin
                    errors++;
                    $display("%0t: reply with none pending, expected none, actual %0d/%0d/%h",
                             $time, rsp_ch.status, rsp_ch.vertex_count, rsp_ch.row_data);
                end
                else
                begin
                    want = graph_replies.pop_front();
                    if (rsp_ch.status !== want.st)
                    begin
                        errors++;
                        $display("%0t: status wrong, expected %0d actual %0d",
                                 $time, want.st, rsp_ch.status);
                    end
                    if (rsp_ch.vertex_count !== want.n)
                    begin
                        errors++;
                        $display("%0t: vertex_count wrong, expected %0d actual %0d",
                                 $time, want.n, rsp_ch.vertex_count);
                    end
                    if (rsp_ch.row_data !== want.data)
                    begin
                        errors++;
                        $display("%0t: row_data wrong, expected %h actual %h",
                                 $time, want.data, rsp_ch.row_data);
                    end
                end
            end
        end
    end

    // Stop a hung run
    initial
    begin : watchdog
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < LIMIT_CYC)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles, %0d replies still pending",
                 cycle_count, graph_replies.size());
        $display("graph_vertex_merge_contract_split_top: mismatch");
        $finish;
    end

    initial
    begin : stimulus
        req_ch.valid     = 1'b0;
        req_ch.mode      = MODE_WRITE;
        req_ch.vertex_a  = '0;
        req_ch.vertex_b  = '0;
        req_ch.row_bits  = '0;
        req_ch.new_count = '0;
        for (int i = 0; i < MAX_V; i++)
            adj_rows[i] = '0;
        adj_count = '0;
        for (int i = 0; i < 8; i++)
            mode_hits[i] = 0;
        for (int i = 0; i < 4; i++)
            status_hits[i] = 0;

        // Directed rows: empty graph, rejected words, full matrix, edge cases of merge
        directed[0]  = table_row(MODE_READ, 0, 0, '0, 0, 1'b1, ST_BAD, 0, '0);
        directed[1]  = table_row(MODE_COUNT, 0, 0, '0, 65, 1'b1, ST_BAD, 0, '0);
        directed[2]  = table_row(MODE_COUNT, 0, 0, '0, 127, 1'b1, ST_BAD, 0, '0);
        directed[3]  = table_row(MODE_SPARE6, 0, 0, '0, 0, 1'b1, ST_BAD, 0, '0);
        directed[4]  = table_row(MODE_SPARE7, 0, 0, '0, 0, 1'b1, ST_BAD, 0, '0);
        directed[5]  = table_row(MODE_SPLIT, 0, 0, '0, 0, 1'b1, ST_BAD, 0, '0);
        directed[6]  = table_row(MODE_IDENTIFY, 0, 1, '0, 0, 1'b1, ST_BAD, 0, '0);
        directed[7]  = table_row(MODE_WRITE, 63, 0, '1, 0, 1'b1, ST_OK, 0, '0);
        directed[8]  = table_row(MODE_COUNT, 0, 0, '0, 64, 1'b1, ST_OK, 64, '0);
        directed[9]  = table_row(MODE_READ, 63, 0, '0, 0, 1'b1, ST_OK, 64, '1);
        directed[10] = table_row(MODE_CONTRACT, 0, 1, '0, 0, 1'b1, ST_NOEDGE, 64, '0);
        directed[11] = table_row(MODE_IDENTIFY, 5, 5, '0, 0, 1'b1, ST_BAD, 64, '0);
        directed[12] = table_row(MODE_CONTRACT, 63, 63, '0, 0, 1'b1, ST_BAD, 64, '0);
        directed[13] = table_row(MODE_SPLIT, 3, 0, '0, 0, 1'b1, ST_FULL, 64, '0);
        directed[14] = table_row(MODE_WRITE, 0, 0, 64'h8000_0000_0000_0006, 0,
                                 1'b1, ST_OK, 64, '0);
        directed[15] = table_row(MODE_CONTRACT, 0, 63, '0, 0, 1'b0, ST_OK, 0, '0);
        directed[16] = table_row(MODE_READ, 0, 0, '0, 0, 1'b0, ST_OK, 0, '0);
        directed[17] = table_row(MODE_IDENTIFY, 62, 0, '0, 0, 1'b0, ST_OK, 0, '0);
        directed[18] = table_row(MODE_READ, 61, 0, '0, 0, 1'b0, ST_OK, 0, '0);
        directed[19] = table_row(MODE_COUNT, 0, 0, '0, 2, 1'b1, ST_OK, 2, '0);
        directed[20] = table_row(MODE_WRITE, 1, 0, 64'h3, 0, 1'b1, ST_OK, 2, '0);
        directed[21] = table_row(MODE_SPLIT, 1, 0, '0, 0, 1'b0, ST_OK, 0, '0);
        directed[22] = table_row(MODE_READ, 2, 0, '0, 0, 1'b0, ST_OK, 0, '0);
        directed[23] = table_row(MODE_IDENTIFY, 1, 2, '0, 0, 1'b0, ST_OK, 0, '0);
        directed[24] = table_row(MODE_COUNT, 0, 0, '0, 0, 1'b1, ST_OK, 0, '0);

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int i = 0; i < DIR_N; i++)
            offer_word(directed[i]);

        // Random words under each idling pattern
        for (int p = 0; p < PHASE_N; p++)
        begin
            case (p)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                    // Back up the reply side so the block stalls its input
                    hold_epoch++;
                end
                1:
                begin
                    send_idle_pct = 66;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 66;
                end
                default:
                begin
                    send_idle_pct = 27;
                    recv_stall_pct = 27;
                end
            endcase
            for (int k = 0; k < RAND_N / PHASE_N; k++)
                offer_word(pick_random_word());
        end
        req_ch.valid <= 1'b0;

        // Drain, then watch for stray replies
        while (graph_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);

        $display("Ran %0d words: %0d write, %0d count, %0d identify, %0d contract, %0d split,",
                 words_sent, mode_hits[MODE_WRITE], mode_hits[MODE_COUNT],
                 mode_hits[MODE_IDENTIFY], mode_hits[MODE_CONTRACT], mode_hits[MODE_SPLIT]);
        $display("%0d read, %0d spare mode; %0d replies (%0d ok, %0d bad, %0d no edge, %0d full)",
                 mode_hits[MODE_READ], mode_hits[MODE_SPARE6] + mode_hits[MODE_SPARE7],
                 words_back, status_hits[ST_OK], status_hits[ST_BAD],
                 status_hits[ST_NOEDGE], status_hits[ST_FULL]);
        if (errors == 0)
            $display("graph_vertex_merge_contract_split_top: match");
        else
            $display("graph_vertex_merge_contract_split_top: mismatch");
        $finish;
    end

endmodule

[graph_vertex_merge_contract_split_top.f]
sv/gvmc_pkg.sv
sv/gvmc_req_if.sv
sv/gvmc_rsp_if.sv
sv/graph_vertex_merge_contract_split_top.sv
test/tb.sv
